// File: rtl/text_console_engine_assert.svh
// Assertion macros for the text console engine
`ifndef TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tce assertion failed");
`define TCE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tce assertion failed");
`else
`define TCE_ASSERT_IMP(name, ante, cons)
`define TCE_ASSERT_NXT(name, ante, cons)
`endif
`endif

// File: rtl/tce_pkg.sv
// Shared types and constants for the text console engine
`timescale 1ns / 1ps
package tce_pkg;

  localparam int MAX_COLUMNS = 80;
  localparam int MAX_ROWS    = 25;
  localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int REQ_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [COL_W-1:0]  RESET_COLS = 7'd80;
  localparam logic [ROW_W-1:0]  RESET_ROWS = 5'd25;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_index;
  } tce_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_position;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_column_out;
    logic              did_scroll;
    logic [CELL_W-1:0] read_cell_value;
  } tce_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep_en;
    logic load_out;
  } tce_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
  } tce_status_t;

endpackage

// File: rtl/tce_ctrl.sv
// Controller state machine for the text console engine
`timescale 1ns / 1ps
`include "text_console_engine_assert.svh"
module tce_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tce_pkg::tce_cmd_t     cmd,
  input  tce_pkg::tce_status_t  status
);
  import tce_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.need_sweep ? S_SWEEP : S_FINISH;
      end
      S_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TCE_ASSERT_IMP(a_no_accept_in_init, state_r == S_INIT, !in_ready)
  `TCE_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid_r || out_ready)
  `TCE_ASSERT_NXT(a_exec_to_finish, state_r == S_EXEC && !status.need_sweep, state_r == S_FINISH)

endmodule

// File: rtl/tce_dpath.sv
// Datapath: text buffer, cursor, geometry registers and buffer sweep
`timescale 1ns / 1ps
`include "text_console_engine_assert.svh"
module tce_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [tce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tce_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  tce_pkg::tce_in_t                    in_data,
  output tce_pkg::tce_out_t                   out_data,
  input  tce_pkg::tce_cmd_t                   cmd,
  output tce_pkg::tce_status_t                status
);
  import tce_pkg::*;

  logic [CELL_W-1:0] mem [0:CELL_COUNT-1];
  logic [CELL_W-1:0] rd_data_r;

  // configuration and clamped geometry
  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  cfg_cols_r;
  logic [ROW_W-1:0]  cfg_rows_r;
  logic [COL_W-1:0]  cols_eff_r, cols_eff_c;
  logic [ROW_W-1:0]  rows_eff_r, rows_eff_c;
  logic [ADDR_W-1:0] cells_r;
  logic [11:0]       cells_prod;

  // request and cursor
  tce_in_t           req_r;
  tce_out_t          out_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic              did_scroll_r;
  logic              rd_ok_r;

  // sweep control
  logic [ADDR_W-1:0] cnt_r, total_r, limit_r;
  logic [CELL_W-1:0] blank_r;
  logic              p_valid_r, p_copy_r;
  logic [ADDR_W-1:0] p_addr_r;
  logic [11:0]       sw_sum;
  logic              sw_copy;

  // request execution
  logic [ROW_W-1:0]  row_c, ex_row;
  logic [COL_W-1:0]  col_c, ex_col;
  logic [11:0]       cur_prod;
  logic [ADDR_W-1:0] cur_idx;
  logic              last_row, last_col;
  logic              ex_scroll, ex_clear, ex_wr_en, ex_rd_en, ex_rd_ok;
  logic [ADDR_W-1:0] ex_waddr;
  logic [CELL_W-1:0] ex_wdata, blank_c;

  // memory ports
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [11:0]       fin_prod;
  logic [ADDR_W-1:0] fin_pos;

  always_comb begin
    if (cfg_cols_r == '0) begin
      cols_eff_c = COL_W'(1);
    end else if (cfg_cols_r > COL_W'(MAX_COLUMNS)) begin
      cols_eff_c = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff_c = cfg_cols_r;
    end
    if (cfg_rows_r == '0) begin
      rows_eff_c = ROW_W'(1);
    end else if (cfg_rows_r > ROW_W'(MAX_ROWS)) begin
      rows_eff_c = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff_c = cfg_rows_r;
    end
    cells_prod = 12'(cols_eff_c) * 12'(rows_eff_c);
  end

  always_comb begin
    blank_c   = {attr_r, CH_SPACE};
    row_c     = (row_r >= rows_eff_r) ? rows_eff_r - ROW_W'(1) : row_r;
    col_c     = (col_r >= cols_eff_r) ? cols_eff_r - COL_W'(1) : col_r;
    cur_prod  = 12'(row_c) * 12'(cols_eff_r);
    cur_idx   = cur_prod[ADDR_W-1:0] + ADDR_W'(col_c);
    last_row  = (row_c == rows_eff_r - ROW_W'(1));
    last_col  = (col_c == cols_eff_r - COL_W'(1));
    ex_row    = row_c;
    ex_col    = col_c;
    ex_scroll = 1'b0;
    ex_clear  = 1'b0;
    ex_wr_en  = 1'b0;
    ex_waddr  = cur_idx;
    ex_wdata  = blank_c;
    ex_rd_en  = 1'b0;
    ex_rd_ok  = 1'b0;
    case (req_r.req_type)
      REQ_PUT: begin
        case (req_r.char_code)
          CH_NEWLINE: begin
            ex_col    = '0;
            ex_row    = row_c + ROW_W'(1);
            ex_scroll = last_row;
          end
          CH_RETURN: begin
            ex_col = '0;
          end
          CH_BACKSPACE: begin
            // erased cell is always the one before the cursor
            ex_waddr = cur_idx - ADDR_W'(1);
            if (col_c != '0) begin
              ex_wr_en = 1'b1;
              ex_col   = col_c - COL_W'(1);
            end else if (row_c != '0) begin
              ex_wr_en = 1'b1;
              ex_row   = row_c - ROW_W'(1);
              ex_col   = cols_eff_r - COL_W'(1);
            end
          end
          default: begin
            ex_wr_en = 1'b1;
            ex_wdata = {attr_r, req_r.char_code};
            if (last_col) begin
              ex_col    = '0;
              ex_row    = row_c + ROW_W'(1);
              ex_scroll = last_row;
            end else begin
              ex_col = col_c + COL_W'(1);
            end
          end
        endcase
        if (ex_scroll) begin
          ex_row = rows_eff_r - ROW_W'(1);
          ex_col = '0;
        end
      end
      REQ_CLEAR: begin
        ex_clear = 1'b1;
        ex_row   = '0;
        ex_col   = '0;
      end
      REQ_READ: begin
        ex_rd_en = 1'b1;
        ex_rd_ok = (req_r.cell_index < cells_r);
      end
      default: begin
        ex_rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    sw_sum            = 12'(cnt_r) + 12'(cols_eff_r);
    sw_copy           = (cnt_r < limit_r);
    status.need_sweep = ex_scroll || ex_clear;
    status.sweep_last = (cnt_r == total_r - ADDR_W'(1));
    mem_we            = p_valid_r || (cmd.exec && ex_wr_en);
    mem_waddr         = p_valid_r ? p_addr_r : ex_waddr;
    mem_wdata         = p_valid_r ? (p_copy_r ? rd_data_r : blank_r) : ex_wdata;
    mem_re            = (cmd.exec && ex_rd_en) || (cmd.sweep_en && sw_copy);
    mem_raddr         = cmd.exec ? req_r.cell_index : sw_sum[ADDR_W-1:0];
    fin_prod          = 12'(row_r) * 12'(cols_eff_r);
    fin_pos           = fin_prod[ADDR_W-1:0] + ADDR_W'(col_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    cols_eff_r <= cols_eff_c;
    rows_eff_r <= rows_eff_c;
    cells_r    <= cells_prod[ADDR_W-1:0];
    p_addr_r   <= cnt_r;
    p_copy_r   <= sw_copy;
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      did_scroll_r <= ex_scroll;
      rd_ok_r      <= ex_rd_ok;
    end
    if (cmd.load_out) begin
      out_r.cursor_position   <= fin_pos;
      out_r.cursor_row_out    <= row_r;
      out_r.cursor_column_out <= col_r;
      out_r.did_scroll        <= did_scroll_r;
      out_r.read_cell_value   <= rd_ok_r ? rd_data_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r     <= RESET_ATTR;
      cfg_cols_r <= RESET_COLS;
      cfg_rows_r <= RESET_ROWS;
      row_r      <= '0;
      col_r      <= '0;
      cnt_r      <= '0;
      total_r    <= ADDR_W'(CELL_COUNT);
      limit_r    <= '0;
      blank_r    <= RESET_CELL;
      p_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ATTR: attr_r     <= cfg_data;
          CFG_COLS: cfg_cols_r <= cfg_data[COL_W-1:0];
          CFG_ROWS: cfg_rows_r <= cfg_data[ROW_W-1:0];
          default: begin
            attr_r <= attr_r;
          end
        endcase
      end
      p_valid_r <= cmd.sweep_en;
      if (cmd.exec) begin
        row_r   <= ex_row;
        col_r   <= ex_col;
        cnt_r   <= '0;
        total_r <= cells_r;
        limit_r <= ex_scroll ? cells_r - ADDR_W'(cols_eff_r) : '0;
        blank_r <= blank_c;
      end else if (cmd.sweep_en) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
    end
  end

  assign out_data = out_r;

  `TCE_ASSERT_IMP(a_single_write, p_valid_r, !(cmd.exec && ex_wr_en))
  `TCE_ASSERT_IMP(a_sweep_in_range, cmd.sweep_en, cnt_r < total_r)
  `TCE_ASSERT_IMP(a_copy_below_limit, p_valid_r && p_copy_r, p_addr_r < limit_r)

endmodule

// File: rtl/text_console_engine.sv
// Top level of the text console engine
`timescale 1ns / 1ps
// Put (other than a scrolling one), read and unused requests go through EXEC and FINISH;
// the result is registered in FINISH, which takes new input once the output is free.
// Scroll and clear walk the buffer one cell per cycle through its single write port:
// every one of the cols * rows cells is rewritten, input held off meanwhile.
// Synchronous active-low reset, then a pass fills all 2000 buffer cells with blanks;
// in_ready stays low during the pass, configuration writes are taken throughout.
module text_console_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tce_pkg::tce_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tce_pkg::tce_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tce_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tce_pkg::*;

  tce_cmd_t    cmd;
  tce_status_t status;

  assign cfg_ready = 1'b1;

  tce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  tce_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
